FILE: rtl/arpm_pkg.sv
// Shared constants, codes, state enums and handshake structs for the level meter.
// Used by every module in rtl; depends on nothing.
`default_nettype none

package arpm_pkg;

  localparam int FracBits   = 23;
  localparam int OutBits    = 16;
  localparam int CountBits  = 32;
  localparam int WordW      = 32;
  localparam int MagW       = FracBits + 1;
  localparam int SqW        = 2 * MagW;
  localparam int SumW       = 64;
  localparam int RmsShift   = 2 * FracBits - 2 * OutBits;
  localparam int DivW       = SumW - RmsShift;
  localparam int LevelW     = OutBits + 1;
  localparam int PeakShift  = FracBits - OutBits;
  localparam int RootW      = OutBits;
  localparam int RadW       = 2 * OutBits;
  localparam int SubW       = CountBits + 1;
  localparam int DivSteps   = DivW;
  localparam int RootSteps  = OutBits;
  localparam int StepCntW   = $clog2(DivSteps);

  typedef enum logic [2:0] {
    FMT_U8    = 3'd0,
    FMT_PCM16 = 3'd1,
    FMT_PCM24 = 3'd2,
    FMT_PCM32 = 3'd3,
    FMT_F32   = 3'd4
  } fmt_e;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_EMIT
  } meter_state_e;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_DIV,
    RS_CHECK,
    RS_SQRT,
    RS_DONE
  } root_state_e;

  typedef struct packed {
    logic                 start;
    logic [DivW-1:0]      dividend;
    logic [CountBits-1:0] divisor;
  } root_req_t;

  typedef struct packed {
    logic              done;
    logic [LevelW-1:0] root;
  } root_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/arpm_decode.sv
// Sample word decoder: raw pcm or float32 bits to a Q1.23 magnitude.
// Depends on arpm_pkg.
`default_nettype none

module arpm_decode (
  input  logic [2:0]                  fmt_i,
  input  logic [arpm_pkg::WordW-1:0]  word_i,
  output logic [arpm_pkg::MagW-1:0]   mag_o,
  output logic                        ok_o
);

  logic signed [arpm_pkg::MagW:0] code;
  logic [arpm_pkg::MagW:0]        code_abs;
  logic [7:0]                     exp_f;
  logic [22:0]                    frac_f;
  logic [7:0]                     shamt;
  logic [arpm_pkg::MagW-1:0]      mant;
  logic [arpm_pkg::MagW-1:0]      fmag;
  logic [arpm_pkg::MagW-1:0]      full;

  assign full   = {1'b1, {(arpm_pkg::MagW-1){1'b0}}};
  assign exp_f  = word_i[30:23];
  assign frac_f = word_i[22:0];
  assign mant   = {(exp_f != 8'd0), frac_f};
  assign shamt  = (exp_f == 8'd0) ? 8'd126 : (8'd127 - exp_f);

  always_comb begin
    if (exp_f == 8'd255) begin
      fmag = (frac_f != 23'd0) ? '0 : full;
    end else if (exp_f >= 8'd127) begin
      fmag = full;
    end else if (shamt >= 8'd24) begin
      fmag = '0;
    end else begin
      fmag = mant >> shamt[4:0];
    end
  end

  always_comb begin
    code = '0;
    ok_o = 1'b1;
    case (fmt_i)
      arpm_pkg::FMT_U8:    code = {~word_i[7], ~word_i[7], word_i[6:0], 16'd0};
      arpm_pkg::FMT_PCM16: code = {word_i[15], word_i[15:0], 8'd0};
      arpm_pkg::FMT_PCM24: code = {word_i[23], word_i[23:0]};
      arpm_pkg::FMT_PCM32: code = {word_i[31], word_i[31:8]};
      arpm_pkg::FMT_F32:   code = '0;
      default:             ok_o = 1'b0;
    endcase
  end

  assign code_abs = code[arpm_pkg::MagW] ? (~code + 1'b1) : code;
  assign mag_o    = (fmt_i == arpm_pkg::FMT_F32) ? fmag : code_abs[arpm_pkg::MagW-1:0];

endmodule

`default_nettype wire

FILE: rtl/arpm_sub_unit.sv
// Shared subtract and compare unit for the divide and square-root steps.
// Depends on arpm_pkg.
`default_nettype none

module arpm_sub_unit (
  input  logic [arpm_pkg::SubW-1:0] a_i,
  input  logic [arpm_pkg::SubW-1:0] b_i,
  output logic [arpm_pkg::SubW-1:0] diff_o,
  output logic                      ge_o
);

  logic [arpm_pkg::SubW:0] wide;

  assign wide   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = wide[arpm_pkg::SubW-1:0];
  assign ge_o   = ~wide[arpm_pkg::SubW];

endmodule

`default_nettype wire

FILE: rtl/arpm_root_seq.sv
// Sequencer for rms: restoring divide of sum by count, then a digit-wise square root.
// Both loops step through one arpm_sub_unit. Depends on arpm_pkg and arpm_sub_unit.
`default_nettype none

module arpm_root_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  arpm_pkg::root_req_t req_i,
  output arpm_pkg::root_rsp_t rsp_o
);

  arpm_pkg::root_state_e state_q, state_d;
  logic [arpm_pkg::StepCntW-1:0]  cnt_q, cnt_d;
  logic [arpm_pkg::DivW-1:0]      quo_q, quo_d;
  logic [arpm_pkg::CountBits-1:0] rem_q, rem_d;
  logic [arpm_pkg::CountBits-1:0] dvs_q, dvs_d;
  logic [arpm_pkg::RootW-1:0]     root_q, root_d;
  logic [arpm_pkg::LevelW-1:0]    res_q, res_d;
  logic [arpm_pkg::SubW-1:0]      sub_a, sub_b, sub_diff;
  logic                           sub_ge;

  arpm_sub_unit u_sub (
    .a_i    (sub_a),
    .b_i    (sub_b),
    .diff_o (sub_diff),
    .ge_o   (sub_ge)
  );

  always_comb begin
    if (state_q == arpm_pkg::RS_SQRT) begin
      sub_a = {rem_q[arpm_pkg::CountBits-2:0], quo_q[arpm_pkg::RadW-1 -: 2]};
      sub_b = {{(arpm_pkg::SubW-arpm_pkg::RootW-2){1'b0}}, root_q, 2'b01};
    end else begin
      sub_a = {rem_q, quo_q[arpm_pkg::DivW-1]};
      sub_b = {1'b0, dvs_q};
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    root_d  = root_q;
    res_d   = res_q;
    rsp_o.done = 1'b0;
    rsp_o.root = res_q;
    case (state_q)
      arpm_pkg::RS_IDLE: begin
        if (req_i.start) begin
          quo_d = req_i.dividend;
          dvs_d = req_i.divisor;
          rem_d = '0;
          cnt_d = arpm_pkg::StepCntW'(arpm_pkg::DivSteps - 1);
          if (req_i.divisor == '0) begin
            res_d   = '0;
            state_d = arpm_pkg::RS_DONE;
          end else begin
            state_d = arpm_pkg::RS_DIV;
          end
        end
      end
      arpm_pkg::RS_DIV: begin
        rem_d = sub_ge ? sub_diff[arpm_pkg::CountBits-1:0] : sub_a[arpm_pkg::CountBits-1:0];
        quo_d = {quo_q[arpm_pkg::DivW-2:0], sub_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = arpm_pkg::RS_CHECK;
        end
      end
      arpm_pkg::RS_CHECK: begin
        rem_d  = '0;
        root_d = '0;
        cnt_d  = arpm_pkg::StepCntW'(arpm_pkg::RootSteps - 1);
        if (quo_q[arpm_pkg::DivW-1:arpm_pkg::RadW] != '0) begin
          res_d   = {1'b1, {arpm_pkg::OutBits{1'b0}}};
          state_d = arpm_pkg::RS_DONE;
        end else begin
          state_d = arpm_pkg::RS_SQRT;
        end
      end
      arpm_pkg::RS_SQRT: begin
        rem_d  = sub_ge ? sub_diff[arpm_pkg::CountBits-1:0] : sub_a[arpm_pkg::CountBits-1:0];
        root_d = {root_q[arpm_pkg::RootW-2:0], sub_ge};
        quo_d  = {quo_q[arpm_pkg::DivW-3:0], 2'b00};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          res_d   = {1'b0, root_q[arpm_pkg::RootW-2:0], sub_ge};
          state_d = arpm_pkg::RS_DONE;
        end
      end
      arpm_pkg::RS_DONE: begin
        rsp_o.done = 1'b1;
        state_d    = arpm_pkg::RS_IDLE;
      end
      default: state_d = arpm_pkg::RS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arpm_pkg::RS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    root_q <= root_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

FILE: rtl/audio_rms_peak_level_meter.sv
// Audio rms and peak level meter: a sample beat passes decode, square and
// accumulate in turn; a silent or unused-format sample beat is taken and dropped. A report
// beat runs the 50-step restoring divide and then the 16-step square root
// that share one 33-bit subtractor (both are skipped when no samples were counted). The
// result sits in an output register, so the meter returns to idle while it waits.
// Depends on arpm_pkg, arpm_decode, arpm_root_seq.
`default_nettype none

module audio_rms_peak_level_meter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [arpm_pkg::WordW-1:0]          sample_word_i,
  input  logic                                silent_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [arpm_pkg::LevelW-1:0]         rms_level_o,
  output logic [arpm_pkg::LevelW-1:0]         peak_level_o,
  output logic [arpm_pkg::CountBits-1:0]      samples_seen_o
);

  arpm_pkg::meter_state_e state_q, state_d;
  arpm_pkg::root_req_t    root_req;
  arpm_pkg::root_rsp_t    root_rsp;

  logic [2:0]                     fmt_q;
  logic [arpm_pkg::MagW-1:0]      dec_mag;
  logic                           dec_ok;
  logic [arpm_pkg::MagW-1:0]      mag_q;
  logic [arpm_pkg::SqW-1:0]       sq_q;
  logic [arpm_pkg::SumW-1:0]      sum_q;
  logic [arpm_pkg::SumW:0]        sum_ext;
  logic [arpm_pkg::MagW-1:0]      peak_q;
  logic [arpm_pkg::CountBits-1:0] count_q;
  logic [arpm_pkg::LevelW-1:0]    pk_snap_q, rms_snap_q;
  logic [arpm_pkg::CountBits-1:0] cnt_snap_q;
  logic                           out_valid_q;
  logic [arpm_pkg::LevelW-1:0]    rms_out_q, pk_out_q;
  logic [arpm_pkg::CountBits-1:0] seen_out_q;
  logic                           in_acc, report_acc, sample_take, out_load;

  arpm_decode u_decode (
    .fmt_i  (fmt_q),
    .word_i (sample_word_i),
    .mag_o  (dec_mag),
    .ok_o   (dec_ok)
  );

  arpm_root_seq u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .rsp_o  (root_rsp)
  );

  assign in_stall_o  = (state_q != arpm_pkg::ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign report_acc  = in_acc & (req_type_i == arpm_pkg::REQ_REPORT);
  assign sample_take = in_acc & (req_type_i == arpm_pkg::REQ_SAMPLE) & ~silent_i & dec_ok;

  assign root_req.start    = report_acc;
  assign root_req.dividend = sum_q[arpm_pkg::SumW-1:arpm_pkg::RmsShift];
  assign root_req.divisor  = count_q;

  assign sum_ext = {1'b0, sum_q} + {{(arpm_pkg::SumW+1-arpm_pkg::SqW){1'b0}}, sq_q};

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      arpm_pkg::ST_IDLE: begin
        if (report_acc) begin
          state_d = arpm_pkg::ST_ROOT;
        end else if (sample_take) begin
          state_d = arpm_pkg::ST_SQUARE;
        end
      end
      arpm_pkg::ST_SQUARE: state_d = arpm_pkg::ST_ACCUM;
      arpm_pkg::ST_ACCUM:  state_d = arpm_pkg::ST_IDLE;
      arpm_pkg::ST_ROOT: begin
        if (root_rsp.done) begin
          state_d = arpm_pkg::ST_EMIT;
        end
      end
      arpm_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = arpm_pkg::ST_IDLE;
        end
      end
      default: state_d = arpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arpm_pkg::ST_IDLE;
      fmt_q       <= arpm_pkg::FMT_PCM16;
      sum_q       <= '0;
      peak_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      if (report_acc) begin
        sum_q   <= '0;
        peak_q  <= '0;
        count_q <= '0;
      end else begin
        if (state_q == arpm_pkg::ST_SQUARE && mag_q > peak_q) begin
          peak_q <= mag_q;
        end
        if (state_q == arpm_pkg::ST_ACCUM) begin
          sum_q <= sum_ext[arpm_pkg::SumW] ? '1 : sum_ext[arpm_pkg::SumW-1:0];
          if (count_q != '1) begin
            count_q <= count_q + 1'b1;
          end
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_take) begin
      mag_q <= dec_mag;
    end
    if (state_q == arpm_pkg::ST_SQUARE) begin
      sq_q <= mag_q * mag_q;
    end
    if (report_acc) begin
      pk_snap_q  <= peak_q[arpm_pkg::MagW-1:arpm_pkg::PeakShift];
      cnt_snap_q <= count_q;
    end
    if (root_rsp.done) begin
      rms_snap_q <= root_rsp.root;
    end
    if (out_load) begin
      rms_out_q  <= rms_snap_q;
      pk_out_q   <= pk_snap_q;
      seen_out_q <= cnt_snap_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rms_level_o    = rms_out_q;
  assign peak_level_o   = pk_out_q;
  assign samples_seen_o = seen_out_q;

`ifndef ASSERT_OFF
  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_acc |=> (sum_q == '0 && peak_q == '0 && count_q == '0))
    else $error("accumulators not cleared after report beat");

  a_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_rsp.done |-> (state_q == arpm_pkg::ST_ROOT))
    else $error("root result outside root wait");

  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rms_level_o <= {1'b1, {arpm_pkg::OutBits{1'b0}}}))
    else $error("rms level above full scale");

  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q <= {1'b1, {(arpm_pkg::MagW-1){1'b0}}})
    else $error("peak magnitude above full scale");
`endif

endmodule

`default_nettype wire
